@@ src/mlt_pkg.sv @@
// ----------------------------------------------------------------------------
// MAC learning table package
// Shared field widths, command codes and the per-cycle operation that the
// top level broadcasts to every table cell.
// ----------------------------------------------------------------------------
package mlt_pkg;

    localparam int MAC_W       = 48;
    localparam int PORT_W      = 4;
    localparam int CMD_W       = 2;
    localparam int TIMEOUT_W   = 8;
    localparam int REMOVED_W   = 7;

    // Cells are grouped for the removal tally that ripples along the row.
    localparam int GRP_SIZE    = 8;
    localparam int GRP_CNT_W   = 4;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd30;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    // Operation seen by all cells in the execute cycle.
    typedef struct packed {
        logic                 exec;
        t_cmd                 cmd;
        logic [MAC_W-1:0]     mac;
        logic [PORT_W-1:0]    port;
        logic [TIMEOUT_W-1:0] timeout;
    } t_cell_op;

endpackage

@@ src/mlt_cell.sv @@
// ----------------------------------------------------------------------------
// MAC learning table cell
// Holds one table entry (valid mark, MAC, port, age), compares its MAC with
// the broadcast address and applies lookup, insert or aging updates. The
// aging removal tally enters from the left neighbor and leaves to the right.
// ----------------------------------------------------------------------------
module mlt_cell #(
    parameter int AGE_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mlt_pkg::t_cell_op              i_op,
    input  logic                           i_grant,
    input  logic [mlt_pkg::GRP_CNT_W-1:0]  i_cnt,
    output logic [mlt_pkg::GRP_CNT_W-1:0]  o_cnt,
    output logic                           o_valid,
    output logic                           o_match,
    output logic [mlt_pkg::PORT_W-1:0]     o_port_sel
);

    localparam int CMP_W = (AGE_BITS > mlt_pkg::TIMEOUT_W) ? AGE_BITS : mlt_pkg::TIMEOUT_W;
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    logic                          r_valid;
    logic [mlt_pkg::MAC_W-1:0]     r_mac;
    logic [mlt_pkg::PORT_W-1:0]    r_port;
    logic [AGE_BITS-1:0]           r_age;

    logic [AGE_BITS-1:0]           w_aged;
    logic                          w_expire;
    logic                          w_tick;

    // Associative compare against the broadcast address.
    assign o_match    = r_valid && (r_mac == i_op.mac);
    assign o_port_sel = o_match ? r_port : '0;
    assign o_valid    = r_valid;

    // Saturating age increment and timeout check for an aging tick.
    assign w_tick   = i_op.exec && (i_op.cmd == mlt_pkg::CMD_TICK);
    assign w_aged   = (r_age < AGE_MAX) ? r_age + AGE_BITS'(1) : r_age;
    assign w_expire = w_tick && r_valid && (CMP_W'(w_aged) >= CMP_W'(i_op.timeout));

    // Removal tally handed on to the next cell.
    assign o_cnt = i_cnt + mlt_pkg::GRP_CNT_W'(w_expire);

    // Valid mark is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_op.exec) begin
            if (i_op.cmd == mlt_pkg::CMD_INSERT && (o_match || i_grant)) begin
                r_valid <= 1'b1;
            end else if (w_expire) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Entry payload.
    always_ff @(posedge i_clk) begin
        if (i_op.exec) begin
            case (i_op.cmd)
                mlt_pkg::CMD_LOOKUP: begin
                    if (o_match) begin
                        r_age <= '0;
                    end
                end
                mlt_pkg::CMD_INSERT: begin
                    if (o_match || i_grant) begin
                        r_mac  <= i_op.mac;
                        r_port <= i_op.port;
                        r_age  <= '0;
                    end
                end
                mlt_pkg::CMD_TICK: begin
                    if (r_valid) begin
                        r_age <= w_aged;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ src/mac_learning_table_aging_top.sv @@
// ----------------------------------------------------------------------------
// MAC learning table with aging, top level
// Result path: the command beat is registered when accepted, the row executes
// and its partial results are registered, then the output register is loaded.
// Command flow: an accept cycle, then an execute cycle in which the whole cell
// row compares and updates in parallel; no command is taken during execute.
// Reset clears all valid marks and sets the timeout to 30.
// ----------------------------------------------------------------------------
module mac_learning_table_aging_top #(
    parameter int TABLE_ENTRIES = 64,
    parameter int AGE_BITS      = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write: aging_timeout
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // Command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // [47:0] mac_addr, [51:48] port_in, [55:52] zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [0] hit, [4:1] port_out, [5] table_full,
                                       // [12:6] removed_count, [15:13] zero
);

    localparam int NG    = (TABLE_ENTRIES + mlt_pkg::GRP_SIZE - 1) / mlt_pkg::GRP_SIZE;
    localparam int SUM_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [SUM_W-1:0] REMOVED_MAX = SUM_W'(127);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state                               r_state;
    logic                                 r_pend;
    logic                                 r_out_valid;
    logic [15:0]                          r_out_data;
    logic [mlt_pkg::TIMEOUT_W-1:0]        r_timeout;

    mlt_pkg::t_cmd                        r_cmd;
    logic [mlt_pkg::MAC_W-1:0]            r_mac;
    logic [mlt_pkg::PORT_W-1:0]           r_port;

    logic                                 r_p_hit;
    logic [mlt_pkg::PORT_W-1:0]           r_p_port;
    logic                                 r_p_full;
    logic [mlt_pkg::GRP_CNT_W-1:0]        r_grp [NG];

    mlt_pkg::t_cell_op                    w_op;
    logic [TABLE_ENTRIES-1:0]             w_valid;
    logic [TABLE_ENTRIES-1:0]             w_match;
    logic [TABLE_ENTRIES-1:0]             w_free;
    logic [TABLE_ENTRIES-1:0]             w_grant;
    logic [mlt_pkg::PORT_W-1:0]           w_port_sel [TABLE_ENTRIES];
    logic [mlt_pkg::GRP_CNT_W-1:0]        w_cnt_in   [TABLE_ENTRIES];
    logic [mlt_pkg::GRP_CNT_W-1:0]        w_cnt_out  [TABLE_ENTRIES];
    logic [mlt_pkg::PORT_W-1:0]           w_port_or;
    logic                                 w_any_match;
    logic                                 w_any_free;
    logic                                 w_out_free;
    logic                                 w_load_out;
    logic                                 w_s_accept;
    logic [SUM_W-1:0]                     w_sum;
    logic [mlt_pkg::REMOVED_W-1:0]        w_removed;
    logic [15:0]                          n_out_data;

    // Handshakes.
    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_load_out    = (r_state == ST_IDLE) && r_pend && w_out_free;
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_pend || w_out_free);
    assign w_s_accept    = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Operation broadcast to the cell row during the execute cycle.
    assign w_op.exec    = (r_state == ST_EXEC);
    assign w_op.cmd     = r_cmd;
    assign w_op.mac     = r_mac;
    assign w_op.port    = r_port;
    assign w_op.timeout = r_timeout;

    // Lowest free cell takes a new MAC; no grant when the MAC is present.
    assign w_free      = ~w_valid;
    assign w_any_match = |w_match;
    assign w_any_free  = |w_free;
    assign w_grant     = (r_cmd == mlt_pkg::CMD_INSERT && !w_any_match)
                         ? (w_free & (w_valid + TABLE_ENTRIES'(1))) : '0;

    // Cell row with the removal tally rippling within each group.
    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
        if (gi % mlt_pkg::GRP_SIZE == 0) begin : g_head
            assign w_cnt_in[gi] = '0;
        end else begin : g_link
            assign w_cnt_in[gi] = w_cnt_out[gi-1];
        end

        mlt_cell #(
            .AGE_BITS (AGE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_op       (w_op),
            .i_grant    (w_grant[gi]),
            .i_cnt      (w_cnt_in[gi]),
            .o_cnt      (w_cnt_out[gi]),
            .o_valid    (w_valid[gi]),
            .o_match    (w_match[gi]),
            .o_port_sel (w_port_sel[gi])
        );
    end

    // Port of the matching cell; at most one cell matches.
    always_comb begin
        w_port_or = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_port_or = w_port_or | w_port_sel[i];
        end
    end

    // Total of the group tallies, saturated to the field range.
    always_comb begin
        w_sum = '0;
        for (int g = 0; g < NG; g++) begin
            w_sum = w_sum + SUM_W'(r_grp[g]);
        end
        w_removed = (w_sum > REMOVED_MAX) ? '1 : mlt_pkg::REMOVED_W'(w_sum);
    end

    always_comb begin
        n_out_data        = '0;
        n_out_data[0]     = r_p_hit;
        n_out_data[4:1]   = r_p_port;
        n_out_data[5]     = r_p_full;
        n_out_data[12:6]  = w_removed;
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_timeout   <= mlt_pkg::TIMEOUT_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_s_accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (r_state == ST_EXEC) begin
                r_pend <= 1'b1;
            end else if (w_load_out) begin
                r_pend <= 1'b0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command beat capture.
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_cmd  <= mlt_pkg::t_cmd'(s_axis_tuser);
            r_mac  <= s_axis_tdata[47:0];
            r_port <= s_axis_tdata[51:48];
        end
    end

    // Partial results from the execute cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC) begin
            r_p_hit  <= (r_cmd == mlt_pkg::CMD_LOOKUP) && w_any_match;
            r_p_port <= (r_cmd == mlt_pkg::CMD_LOOKUP) ? w_port_or : '0;
            r_p_full <= (r_cmd == mlt_pkg::CMD_INSERT) && !w_any_match && !w_any_free;
            for (int g = 0; g < NG; g++) begin
                r_grp[g] <= w_cnt_out[((g + 1) * mlt_pkg::GRP_SIZE > TABLE_ENTRIES)
                                      ? TABLE_ENTRIES - 1
                                      : (g + 1) * mlt_pkg::GRP_SIZE - 1];
            end
        end
        if (w_load_out) begin
            r_out_data <= n_out_data;
        end
    end

    // A MAC is never held by two valid cells.
    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one cell matches the MAC");

    // An insert claims at most one free cell.
    a_single_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_grant))
        else $error("insert granted to more than one cell");

    // No command is taken while the row executes.
    a_no_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> !s_axis_tready)
        else $error("command accepted during execute cycle");

    // Every accepted command leaves a pending result after execution.
    a_result_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept |=> ##1 r_pend)
        else $error("accepted command produced no pending result");

endmodule
